/* hw/rtl/aprf_pkg.sv */
// Types, round constants and the round function of the keyed permutation PRF.
package aprf_pkg;

    localparam int WORD_W    = 64;
    localparam int NUM_WORDS = 5;
    localparam int MAX_ROUNDS = 12;
    localparam int RIDX_W    = 4;
    localparam int ADDR_W    = 4;

    // Register map, indexed by paddr[3]
    localparam logic REG_KEY_FIRST  = 1'b0;
    localparam logic REG_KEY_SECOND = 1'b1;

    typedef logic [WORD_W-1:0] t_word;
    typedef t_word t_state [NUM_WORDS];

    function automatic logic [7:0] round_const(input logic [RIDX_W-1:0] idx);
        logic [7:0] c;
        case (idx)
            4'd0:    c = 8'hf0;
            4'd1:    c = 8'he1;
            4'd2:    c = 8'hd2;
            4'd3:    c = 8'hc3;
            4'd4:    c = 8'hb4;
            4'd5:    c = 8'ha5;
            4'd6:    c = 8'h96;
            4'd7:    c = 8'h87;
            4'd8:    c = 8'h78;
            4'd9:    c = 8'h69;
            4'd10:   c = 8'h5a;
            4'd11:   c = 8'h4b;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic t_word ror64(input t_word v, input int n);
        return (v >> n) | (v << (WORD_W - n));
    endfunction

    // One round: constant addition, substitution layer, linear layer
    function automatic t_state perm_round(input t_state s, input logic [RIDX_W-1:0] idx);
        t_word  x0, x1, x2, x3, x4;
        t_word  t0, t1, t2, t3, t4;
        t_state o;
        x0 = s[0];
        x1 = s[1];
        x2 = s[2] ^ {{(WORD_W-8){1'b0}}, round_const(idx)};
        x3 = s[3];
        x4 = s[4];
        x0 = x0 ^ x4;
        x4 = x4 ^ x3;
        x2 = x2 ^ x1;
        t0 = x0 ^ (~x1 & x2);
        t1 = x1 ^ (~x2 & x3);
        t2 = x2 ^ (~x3 & x4);
        t3 = x3 ^ (~x4 & x0);
        t4 = x4 ^ (~x0 & x1);
        t1 = t1 ^ t0;
        t0 = t0 ^ t4;
        t3 = t3 ^ t2;
        t2 = ~t2;
        o[0] = t0 ^ ror64(t0, 19) ^ ror64(t0, 28);
        o[1] = t1 ^ ror64(t1, 61) ^ ror64(t1, 39);
        o[2] = t2 ^ ror64(t2, 1)  ^ ror64(t2, 6);
        o[3] = t3 ^ ror64(t3, 10) ^ ror64(t3, 17);
        o[4] = t4 ^ ror64(t4, 7)  ^ ror64(t4, 41);
        return o;
    endfunction

endpackage

/* hw/rtl/ascon_keyed_prf.sv */
// Keyed PRF over the Ascon permutation: load stage plus one pipeline stage per round.
// The load register fills at the accepting edge, then one register stage per permutation
// round carries the item through to output valid.
// Throughput: one item per cycle; each stage holds on its own, so bubbles collapse
// under output stall and the input stalls only when every stage is full.
// Reset (i_rst_n low, synchronous) clears all stage valid bits and both key words.
module ascon_keyed_prf
    import aprf_pkg::*;
#(
    parameter int ROUNDS = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // config port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [ADDR_W-1:0]    paddr,
    input  logic [WORD_W-1:0]    pwdata,
    output logic [WORD_W-1:0]    prdata,
    output logic                 pready,
    // input channel
    input  logic                 i_valid,
    output logic                 o_stall,
    input  logic [WORD_W-1:0]    i_domain_tag,
    input  logic [WORD_W-1:0]    i_block_first_word,
    input  logic [WORD_W-1:0]    i_block_second_word,
    // output channel
    output logic                 o_valid,
    input  logic                 i_stall,
    output logic [WORD_W-1:0]    o_tag_first_word,
    output logic [WORD_W-1:0]    o_tag_second_word
);

    localparam int FIRST_IDX = MAX_ROUNDS - ROUNDS;

    logic [WORD_W-1:0] r_key_first;
    logic [WORD_W-1:0] r_key_second;

    logic              r_vld [ROUNDS+1];
    t_state            r_st  [ROUNDS+1];
    logic [ROUNDS+1:0] stage_rdy;

    // ---------------- config registers
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_first  <= '0;
            r_key_second <= '0;
        end else if (psel && penable && pwrite) begin
            case (paddr[3])
                REG_KEY_FIRST:  r_key_first  <= pwdata;
                REG_KEY_SECOND: r_key_second <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3])
            REG_KEY_FIRST:  prdata = r_key_first;
            REG_KEY_SECOND: prdata = r_key_second;
            default:        prdata = '0;
        endcase
    end

    // ---------------- stage flow control
    assign stage_rdy[ROUNDS+1] = !i_stall;

    genvar k;
    generate
        for (k = 0; k <= ROUNDS; k++) begin : g_rdy
            assign stage_rdy[k] = !r_vld[k] || stage_rdy[k+1];
        end
    endgenerate

    assign o_stall = !stage_rdy[0];

    // ---------------- load stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld[0] <= 1'b0;
        end else if (stage_rdy[0]) begin
            r_vld[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (stage_rdy[0] && i_valid) begin
            r_st[0][0] <= i_domain_tag;
            r_st[0][1] <= r_key_first;
            r_st[0][2] <= r_key_second;
            r_st[0][3] <= i_block_first_word;
            r_st[0][4] <= i_block_second_word;
        end
    end

    // ---------------- round stages
    generate
        for (k = 1; k <= ROUNDS; k++) begin : g_round
            localparam logic [RIDX_W-1:0] RIDX = RIDX_W'(FIRST_IDX + k - 1);

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[k] <= 1'b0;
                end else if (stage_rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end

            always_ff @(posedge i_clk) begin
                if (stage_rdy[k] && r_vld[k-1]) begin
                    r_st[k] <= perm_round(r_st[k-1], RIDX);
                end
            end
        end
    endgenerate

    assign o_valid           = r_vld[ROUNDS];
    assign o_tag_first_word  = r_st[ROUNDS][0];
    assign o_tag_second_word = r_st[ROUNDS][1];

endmodule

/* verif/ascon_keyed_prf_tb.sv */
// Self-checking testbench for the keyed Ascon-permutation PRF: key setup, block stream, tag check.
module ascon_keyed_prf_tb;
    import aprf_pkg::*;

    localparam int PRF_ROUNDS  = 12;
    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 275;

    typedef struct packed {
        t_word first;
        t_word second;
    } t_tag_pair;

    // Tracks the key registers, predicts the tag of each accepted block and checks results
    class prf_tag_tracker;
        int        rounds;
        t_word     key_first;
        t_word     key_second;
        t_tag_pair tag_q[$];
        int        errors;

        function new(int n_rounds);
            rounds     = n_rounds;
            key_first  = '0;
            key_second = '0;
            errors     = 0;
        endfunction

        static function t_word rotr(t_word x, int n);
            logic [2*WORD_W-1:0] d;
            d = {x, x} >> n;
            return d[WORD_W-1:0];
        endfunction

        static function t_word mix(t_word x, int a, int b);
            return x ^ rotr(x, a) ^ rotr(x, b);
        endfunction

        function t_tag_pair ascon_tag(t_word dom, t_word blk0, t_word blk1);
            t_word     w[5];
            t_word     t[5];
            logic [7:0] rc;
            t_tag_pair r;
            w = '{dom, key_first, key_second, blk0, blk1};
            for (int i = MAX_ROUNDS - rounds; i < MAX_ROUNDS; i++) begin
                // constants run f0, e1, d2, ...: high nibble counts down, low nibble up
                rc = 8'((15 - i) * 16 + i);
                w[2] = w[2] ^ {{(WORD_W-8){1'b0}}, rc};
                w[0] = w[0] ^ w[4];
                w[4] = w[4] ^ w[3];
                w[2] = w[2] ^ w[1];
                for (int k = 0; k < 5; k++)
                    t[k] = w[k] ^ (~w[(k+1)%5] & w[(k+2)%5]);
                t[1] = t[1] ^ t[0];
                t[0] = t[0] ^ t[4];
                t[3] = t[3] ^ t[2];
                t[2] = ~t[2];
                w[0] = mix(t[0], 19, 28);
                w[1] = mix(t[1], 61, 39);
                w[2] = mix(t[2], 1, 6);
                w[3] = mix(t[3], 10, 17);
                w[4] = mix(t[4], 7, 41);
            end
            r.first  = w[0];
            r.second = w[1];
            return r;
        endfunction

        function void set_key(logic sel, t_word value);
            if (sel == REG_KEY_FIRST) key_first = value;
            else key_second = value;
        endfunction

        function void check_key(logic sel, t_word value);
            t_word want;
            want = (sel == REG_KEY_FIRST) ? key_first : key_second;
            if (value !== want) begin
                errors++;
                $display("%0t: key register %0d readback expected %h actual %h",
                         $time, sel, want, value);
            end
        endfunction

        function void add_block(t_word dom, t_word blk0, t_word blk1);
            tag_q.push_back(ascon_tag(dom, blk0, blk1));
        endfunction

        function void check_tag(t_word first, t_word second);
            t_tag_pair want;
            if (tag_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected tag, expected none actual %h %h", $time, first, second);
                return;
            end
            want = tag_q.pop_front();
            if (first !== want.first) begin
                errors++;
                $display("%0t: tag_first_word expected %h actual %h", $time, want.first, first);
            end
            if (second !== want.second) begin
                errors++;
                $display("%0t: tag_second_word expected %h actual %h", $time, want.second, second);
            end
        endfunction

        function int pending();
            return tag_q.size();
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [WORD_W-1:0] pwdata;
    logic [WORD_W-1:0] prdata;
    logic              pready;
    logic              i_valid;
    logic              o_stall;
    logic [WORD_W-1:0] i_domain_tag;
    logic [WORD_W-1:0] i_block_first_word;
    logic [WORD_W-1:0] i_block_second_word;
    logic              o_valid;
    logic              i_stall;
    logic [WORD_W-1:0] o_tag_first_word;
    logic [WORD_W-1:0] o_tag_second_word;

    prf_tag_tracker tracker;
    int             cycle_count;
    int             burst_left;
    int             stall_mode;
    int             stall_left;

    ascon_keyed_prf #(.ROUNDS(PRF_ROUNDS)) dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready),
        .i_valid             (i_valid),
        .o_stall             (o_stall),
        .i_domain_tag        (i_domain_tag),
        .i_block_first_word  (i_block_first_word),
        .i_block_second_word (i_block_second_word),
        .o_valid             (o_valid),
        .i_stall             (i_stall),
        .o_tag_first_word    (o_tag_first_word),
        .o_tag_second_word   (o_tag_second_word)
    );

    initial begin
        i_clk               = 1'b0;
        i_rst_n             = 1'b0;
        psel                = 1'b0;
        penable             = 1'b0;
        pwrite              = 1'b0;
        paddr               = '0;
        pwdata              = '0;
        i_valid             = 1'b0;
        i_stall             = 1'b0;
        i_domain_tag        = '0;
        i_block_first_word  = '0;
        i_block_second_word = '0;
        cycle_count         = 0;
        burst_left          = 0;
        stall_mode          = 0;
        stall_left          = 0;
        tracker             = new(PRF_ROUNDS);
    end

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("ascon_keyed_prf: mismatch");
            $finish;
        end
    end

    // receiver: stall behavior changes at random intervals among four modes
    always @(negedge i_clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 3);
            stall_left = $urandom_range(20, 200);
        end else begin
            stall_left = stall_left - 1;
        end
        case (stall_mode)
            0: i_stall <= 1'b0;
            1: i_stall <= ($urandom_range(0, 3) == 0);
            2: i_stall <= ($urandom_range(0, 3) != 0);
            default: i_stall <= ((cycle_count % 7) < 3);
        endcase
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            tracker.check_tag(o_tag_first_word, o_tag_second_word);
    end

    // called at a falling edge, returns at a falling edge
    task automatic reg_access(input logic wr, input logic sel, input t_word value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_W'({sel, 3'b000});
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (wr) tracker.set_key(sel, value);
        else tracker.check_key(sel, prdata);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic idle_input(input int n);
        i_valid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic wait_drain();
        idle_input(1);
        while (tracker.pending() != 0) @(negedge i_clk);
        repeat (PRF_ROUNDS + 4) @(negedge i_clk);
    endtask

    task automatic load_key(input t_word k0, input t_word k1);
        wait_drain();
        reg_access(1'b1, REG_KEY_FIRST, k0);
        reg_access(1'b1, REG_KEY_SECOND, k1);
        reg_access(1'b0, REG_KEY_FIRST, '0);
        reg_access(1'b0, REG_KEY_SECOND, '0);
    endtask

    task automatic send_block(input t_word dom, input t_word blk0, input t_word blk1);
        i_valid             <= 1'b1;
        i_domain_tag        <= dom;
        i_block_first_word  <= blk0;
        i_block_second_word <= blk1;
        do @(posedge i_clk); while (o_stall);
        tracker.add_block(dom, blk0, blk1);
        @(negedge i_clk);
    endtask

    function automatic t_word pick_word();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return t_word'(1) << $urandom_range(0, WORD_W - 1);
            3: return ~(t_word'(1) << $urandom_range(0, WORD_W - 1));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    task automatic send_random(input int count);
        for (int n = 0; n < count; n++) begin
            if (burst_left == 0) begin
                burst_left = $urandom_range(1, 40);
                if ($urandom_range(0, 3) != 0) idle_input($urandom_range(1, 8));
            end
            burst_left--;
            send_block(pick_word(), pick_word(), pick_word());
        end
    endtask

    task automatic send_corners();
        for (int c = 0; c < 8; c++)
            send_block(c[0] ? '1 : '0, c[1] ? '1 : '0, c[2] ? '1 : '0);
    endtask

    initial begin
        t_word k0;
        t_word k1;
        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset key (all zero), then the all-ones key
        send_corners();
        send_block(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 64'h1);
        send_block(64'haaaa_aaaa_aaaa_aaaa, 64'h8000_0000_0000_0000, 64'h5555_5555_5555_5555);
        load_key('1, '1);
        send_corners();

        for (int p = 0; p < 6; p++) begin
            case (p)
                0: begin k0 = '0; k1 = '1; end
                1: begin k0 = '1; k1 = '0; end
                2: begin k0 = 64'h8000_0000_0000_0000; k1 = 64'h1; end
                default: begin k0 = {$urandom, $urandom}; k1 = {$urandom, $urandom}; end
            endcase
            load_key(k0, k1);
            send_random(PHASE_ITEMS);
        end

        wait_drain();
        if (tracker.errors == 0)
            $display("ascon_keyed_prf: match");
        else
            $display("ascon_keyed_prf: mismatch");
        $finish;
    end

endmodule
